// ===== rtl/core/i2cmbe_pkg.sv =====
`timescale 1ns / 1ps

package i2cmbe_pkg;

    // Fixed widths of the bus fields
    localparam int BYTE_BITS       = 8;
    localparam int REQ_W           = 3;
    localparam int TICKS_W         = 16;
    localparam int POLL_LIMIT_W    = 4;
    localparam int POLL_COUNT_W    = POLL_LIMIT_W + 1;
    localparam int BIT_INDEX_W     = 4;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 16;

    // Default width of the bus-delay counter
    localparam int TICK_COUNT_WIDTH_DEF = 16;

    // Register values after reset
    localparam logic [TICKS_W-1:0]      HALF_PERIOD_RST   = 16'd50;
    localparam logic [POLL_LIMIT_W-1:0] POLL_LIMIT_RST    = 4'd10;
    localparam logic [TICKS_W-1:0]      POLL_INTERVAL_RST = 16'd2;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_PERIOD   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_POLL_LIMIT    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_POLL_INTERVAL = 2'd2;

    // Command codes
    localparam logic [REQ_W-1:0] REQ_START    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_STOP     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_WRITE    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_WAIT_ACK = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ     = 3'd4;
    localparam logic [REQ_W-1:0] REQ_ACK      = 3'd5;
    localparam logic [REQ_W-1:0] REQ_NACK     = 3'd6;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_ST0, PH_ST1, PH_ST2, PH_ST3,
        PH_SP0, PH_SP1, PH_SP2, PH_SP3,
        PH_WR0, PH_WRH, PH_WRL,
        PH_AK0, PH_AKP,
        PH_RD0, PH_RDL, PH_RDH,
        PH_KA0, PH_KA1, PH_KA2
    } phase_t;

    typedef struct packed {
        logic [TICKS_W-1:0]      half_period;
        logic [POLL_LIMIT_W-1:0] poll_limit;
        logic [TICKS_W-1:0]      poll_interval;
    } cfg_t;

    typedef struct packed {
        logic                 scl;
        logic                 sda;
        logic                 sda_drive;
        logic                 ready;
        logic                 done;
        logic [BYTE_BITS-1:0] read_data;
        logic                 ack_timeout;
    } res_t;

endpackage

// ===== rtl/core/i2c_master_bit_engine.sv =====
`timescale 1ns / 1ps

// I2C master pin sequencer. Every input item is one bus tick: it carries the
// synchronized SDA level and, while ready_res was last shown high, an optional
// command (start, stop, write byte MSB first, wait for ACK, read byte, send
// ACK, send NACK). Each item yields exactly one result item with the SCL level,
// the SDA level and drive enable after that tick, plus ready_res, a one-tick
// done_res pulse, the last read byte and the ACK timeout flag. A command
// arriving while busy is ignored. Bus delays are half_period_ticks ticks long,
// except the SCL-low phase between written bits, which gets no added delay;
// ACK polling samples SDA every poll_interval_ticks ticks and gives up on a
// high sample once more than ack_poll_limit retries are done, leaving SCL high
// and SDA released. Rate: one item per clock; the state update and the result
// register sit behind a single level of next-state logic, so an item is taken
// every cycle while out_ready is high or the result register is empty, and its
// result is shown in the cycle after acceptance. Write configuration registers
// only while the engine is idle and no result is pending.
module i2c_master_bit_engine #(
    parameter int TICK_COUNT_WIDTH = i2cmbe_pkg::TICK_COUNT_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  cmd_valid,
    input  logic [i2cmbe_pkg::REQ_W-1:0]          req_type,
    input  logic [i2cmbe_pkg::BYTE_BITS-1:0]      write_byte,
    input  logic                                  sda_in,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  scl_level,
    output logic                                  sda_level,
    output logic                                  sda_drive,
    output logic                                  ready_res,
    output logic                                  done_res,
    output logic [i2cmbe_pkg::BYTE_BITS-1:0]      read_data,
    output logic                                  ack_timeout,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [i2cmbe_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [i2cmbe_pkg::CFG_DATA_W-1:0]     cfg_data
);

    i2cmbe_pkg::cfg_t cfg_reg;
    i2cmbe_pkg::res_t res_next;
    i2cmbe_pkg::res_t res_reg;
    logic             out_valid_reg;
    logic             step;

    // Take a new item whenever the result register is empty or being drained
    assign in_ready  = !out_valid_reg || out_ready;
    assign step      = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Configuration registers; an index past the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period   <= i2cmbe_pkg::HALF_PERIOD_RST;
            cfg_reg.poll_limit    <= i2cmbe_pkg::POLL_LIMIT_RST;
            cfg_reg.poll_interval <= i2cmbe_pkg::POLL_INTERVAL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                i2cmbe_pkg::CFG_HALF_PERIOD:
                    cfg_reg.half_period <= cfg_data[i2cmbe_pkg::TICKS_W-1:0];
                i2cmbe_pkg::CFG_POLL_LIMIT:
                    cfg_reg.poll_limit <= cfg_data[i2cmbe_pkg::POLL_LIMIT_W-1:0];
                i2cmbe_pkg::CFG_POLL_INTERVAL:
                    cfg_reg.poll_interval <= cfg_data[i2cmbe_pkg::TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer: holds the bus state and advances it by one tick per item
    i2cmbe_seq #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .cmd_valid  (cmd_valid),
        .req_type   (req_type),
        .write_byte (write_byte),
        .sda_in     (sda_in),
        .cfg        (cfg_reg),
        .res_next   (res_next)
    );

    // Result register: hold until taken, load on every accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign scl_level   = res_reg.scl;
    assign sda_level   = res_reg.sda;
    assign sda_drive   = res_reg.sda_drive;
    assign ready_res   = res_reg.ready;
    assign done_res    = res_reg.done;
    assign read_data   = res_reg.read_data;
    assign ack_timeout = res_reg.ack_timeout;

endmodule

// ===== rtl/core/i2cmbe_seq.sv =====
`timescale 1ns / 1ps

module i2cmbe_seq #(
    parameter int TICK_COUNT_WIDTH = i2cmbe_pkg::TICK_COUNT_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  logic                              cmd_valid,
    input  logic [i2cmbe_pkg::REQ_W-1:0]      req_type,
    input  logic [i2cmbe_pkg::BYTE_BITS-1:0]  write_byte,
    input  logic                              sda_in,
    input  i2cmbe_pkg::cfg_t                  cfg,
    output i2cmbe_pkg::res_t                  res_next
);

    localparam int TW = TICK_COUNT_WIDTH;
    localparam int KW = i2cmbe_pkg::TICKS_W;
    localparam int BB = i2cmbe_pkg::BYTE_BITS;
    localparam int BW = i2cmbe_pkg::BIT_INDEX_W;
    localparam int PW = i2cmbe_pkg::POLL_COUNT_W;

    i2cmbe_pkg::phase_t phase_reg, phase_next;
    logic [TW-1:0] wait_reg, wait_next;
    logic [BW-1:0] bit_index_reg, bit_index_next;
    logic [BB-1:0] shift_reg, shift_next;
    logic [PW-1:0] poll_count_reg, poll_count_next;
    logic scl_reg, scl_next;
    logic sda_reg, sda_next;
    logic sda_drive_reg, sda_drive_next;
    logic ack_fail_reg, ack_fail_next;
    logic [BB-1:0] read_reg, read_next;
    logic done_next;

    logic [KW-1:0]    half_m1, poll_m1;
    logic [TW+KW-1:0] half_wide, poll_wide;
    logic [TW-1:0]    half_load, poll_load;
    logic [BW-1:0]    bit_inc;
    logic             byte_end;
    logic             wait_zero;

    // A delay of d ticks loads d-1; zero acts as one. Fit to the counter width.
    assign half_m1   = (cfg.half_period == '0) ? '0 : cfg.half_period - 1'b1;
    assign poll_m1   = (cfg.poll_interval == '0) ? '0 : cfg.poll_interval - 1'b1;
    assign half_wide = {{TW{1'b0}}, half_m1};
    assign poll_wide = {{TW{1'b0}}, poll_m1};
    assign half_load = half_wide[TW-1:0];
    assign poll_load = poll_wide[TW-1:0];

    assign bit_inc   = bit_index_reg + 1'b1;
    assign byte_end  = (bit_inc >= BW'(BB));
    assign wait_zero = (wait_reg == '0);

    // Phase and delay counter
    always_comb
    begin
        phase_next = phase_reg;
        wait_next  = wait_reg;
        done_next  = 1'b0;
        if (phase_reg == i2cmbe_pkg::PH_IDLE)
        begin
            if (cmd_valid)
            begin
                case (req_type)
                    i2cmbe_pkg::REQ_START:    begin phase_next = i2cmbe_pkg::PH_ST0; wait_next = half_load; end
                    i2cmbe_pkg::REQ_STOP:     begin phase_next = i2cmbe_pkg::PH_SP0; wait_next = half_load; end
                    i2cmbe_pkg::REQ_WRITE:    begin phase_next = i2cmbe_pkg::PH_WR0; wait_next = half_load; end
                    i2cmbe_pkg::REQ_WAIT_ACK: begin phase_next = i2cmbe_pkg::PH_AK0; wait_next = half_load; end
                    i2cmbe_pkg::REQ_READ:     begin phase_next = i2cmbe_pkg::PH_RD0; wait_next = half_load; end
                    i2cmbe_pkg::REQ_ACK,
                    i2cmbe_pkg::REQ_NACK:     begin phase_next = i2cmbe_pkg::PH_KA0; wait_next = half_load; end
                    default: ;
                endcase
            end
        end
        else if (!wait_zero)
        begin
            wait_next = wait_reg - 1'b1;
        end
        else
        begin
            case (phase_reg)
                i2cmbe_pkg::PH_ST0: begin phase_next = i2cmbe_pkg::PH_ST1; wait_next = half_load; end
                i2cmbe_pkg::PH_ST1: begin phase_next = i2cmbe_pkg::PH_ST2; wait_next = half_load; end
                i2cmbe_pkg::PH_ST2: begin phase_next = i2cmbe_pkg::PH_ST3; wait_next = half_load; end
                i2cmbe_pkg::PH_SP0: begin phase_next = i2cmbe_pkg::PH_SP1; wait_next = half_load; end
                i2cmbe_pkg::PH_SP1: begin phase_next = i2cmbe_pkg::PH_SP2; wait_next = half_load; end
                i2cmbe_pkg::PH_SP2: begin phase_next = i2cmbe_pkg::PH_SP3; wait_next = half_load; end
                i2cmbe_pkg::PH_ST3,
                i2cmbe_pkg::PH_SP3,
                i2cmbe_pkg::PH_KA2:
                begin
                    phase_next = i2cmbe_pkg::PH_IDLE;
                    done_next  = 1'b1;
                end
                i2cmbe_pkg::PH_WR0,
                i2cmbe_pkg::PH_WRL: begin phase_next = i2cmbe_pkg::PH_WRH; wait_next = half_load; end
                i2cmbe_pkg::PH_WRH:
                begin
                    if (byte_end)
                    begin
                        phase_next = i2cmbe_pkg::PH_IDLE;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        phase_next = i2cmbe_pkg::PH_WRL;
                        wait_next  = '0;
                    end
                end
                i2cmbe_pkg::PH_AK0: begin phase_next = i2cmbe_pkg::PH_AKP; wait_next = '0; end
                i2cmbe_pkg::PH_AKP:
                begin
                    if (!sda_in || (poll_count_reg > {1'b0, cfg.poll_limit}))
                    begin
                        phase_next = i2cmbe_pkg::PH_IDLE;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        wait_next = poll_load;
                    end
                end
                i2cmbe_pkg::PH_RD0: begin phase_next = i2cmbe_pkg::PH_RDL; wait_next = half_load; end
                i2cmbe_pkg::PH_RDL: begin phase_next = i2cmbe_pkg::PH_RDH; wait_next = half_load; end
                i2cmbe_pkg::PH_RDH:
                begin
                    if (byte_end)
                    begin
                        phase_next = i2cmbe_pkg::PH_IDLE;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        phase_next = i2cmbe_pkg::PH_RDL;
                        wait_next  = half_load;
                    end
                end
                i2cmbe_pkg::PH_KA0: begin phase_next = i2cmbe_pkg::PH_KA1; wait_next = half_load; end
                i2cmbe_pkg::PH_KA1: begin phase_next = i2cmbe_pkg::PH_KA2; wait_next = half_load; end
                default: phase_next = i2cmbe_pkg::PH_IDLE;
            endcase
        end
    end

    // Pins, shifter and status
    always_comb
    begin
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        sda_drive_next  = sda_drive_reg;
        shift_next      = shift_reg;
        bit_index_next  = bit_index_reg;
        poll_count_next = poll_count_reg;
        ack_fail_next   = ack_fail_reg;
        read_next       = read_reg;
        if (phase_reg == i2cmbe_pkg::PH_IDLE)
        begin
            if (cmd_valid)
            begin
                case (req_type)
                    i2cmbe_pkg::REQ_START: sda_drive_next = 1'b1;
                    i2cmbe_pkg::REQ_STOP:
                    begin
                        scl_next       = 1'b0;
                        sda_drive_next = 1'b1;
                    end
                    i2cmbe_pkg::REQ_WRITE:
                    begin
                        scl_next       = 1'b0;
                        sda_drive_next = 1'b1;
                        shift_next     = write_byte;
                        bit_index_next = '0;
                    end
                    i2cmbe_pkg::REQ_WAIT_ACK:
                    begin
                        scl_next        = 1'b0;
                        sda_drive_next  = 1'b0;
                        poll_count_next = '0;
                    end
                    i2cmbe_pkg::REQ_READ:
                    begin
                        scl_next       = 1'b0;
                        sda_drive_next = 1'b0;
                        shift_next     = '0;
                        bit_index_next = '0;
                    end
                    i2cmbe_pkg::REQ_ACK,
                    i2cmbe_pkg::REQ_NACK:
                    begin
                        scl_next       = 1'b0;
                        sda_drive_next = 1'b1;
                        sda_next       = (req_type == i2cmbe_pkg::REQ_NACK);
                    end
                    default: ;
                endcase
            end
        end
        else if (wait_zero)
        begin
            case (phase_reg)
                i2cmbe_pkg::PH_ST0,
                i2cmbe_pkg::PH_SP0:
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b0;
                end
                i2cmbe_pkg::PH_ST1:
                begin
                    sda_next = 1'b1;
                    scl_next = 1'b1;
                end
                i2cmbe_pkg::PH_ST2: sda_next = 1'b0;
                i2cmbe_pkg::PH_SP1: scl_next = 1'b1;
                i2cmbe_pkg::PH_SP2: sda_next = 1'b1;
                i2cmbe_pkg::PH_ST3,
                i2cmbe_pkg::PH_SP3,
                i2cmbe_pkg::PH_RD0,
                i2cmbe_pkg::PH_KA1: scl_next = 1'b0;
                i2cmbe_pkg::PH_WR0,
                i2cmbe_pkg::PH_WRL:
                begin
                    // MSB first
                    sda_next   = shift_reg[BB-1];
                    shift_next = {shift_reg[BB-2:0], 1'b0};
                    scl_next   = 1'b1;
                end
                i2cmbe_pkg::PH_WRH:
                begin
                    scl_next       = 1'b0;
                    bit_index_next = bit_inc;
                end
                i2cmbe_pkg::PH_AK0,
                i2cmbe_pkg::PH_RDL,
                i2cmbe_pkg::PH_KA0: scl_next = 1'b1;
                i2cmbe_pkg::PH_AKP:
                begin
                    if (!sda_in)
                    begin
                        scl_next      = 1'b0;
                        ack_fail_next = 1'b0;
                    end
                    else if (poll_count_reg > {1'b0, cfg.poll_limit})
                    begin
                        // SCL stays high on timeout
                        ack_fail_next = 1'b1;
                    end
                    else
                    begin
                        poll_count_next = poll_count_reg + 1'b1;
                    end
                end
                i2cmbe_pkg::PH_RDH:
                begin
                    shift_next     = {shift_reg[BB-2:0], sda_in};
                    bit_index_next = bit_inc;
                    if (byte_end)
                        read_next = {shift_reg[BB-2:0], sda_in};
                    else
                        scl_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= i2cmbe_pkg::PH_IDLE;
            wait_reg       <= '0;
            bit_index_reg  <= '0;
            shift_reg      <= '0;
            poll_count_reg <= '0;
            scl_reg        <= 1'b0;
            sda_reg        <= 1'b0;
            sda_drive_reg  <= 1'b1;
            ack_fail_reg   <= 1'b0;
            read_reg       <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            wait_reg       <= wait_next;
            bit_index_reg  <= bit_index_next;
            shift_reg      <= shift_next;
            poll_count_reg <= poll_count_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            sda_drive_reg  <= sda_drive_next;
            ack_fail_reg   <= ack_fail_next;
            read_reg       <= read_next;
        end
    end

    assign res_next.scl         = scl_next;
    assign res_next.sda         = sda_next;
    assign res_next.sda_drive   = sda_drive_next;
    assign res_next.ready       = (phase_next == i2cmbe_pkg::PH_IDLE);
    assign res_next.done        = done_next;
    assign res_next.read_data   = read_next;
    assign res_next.ack_timeout = ack_fail_next;

endmodule
